// ===== design/chs_pkg.sv =====
// shared types, register indexes and the arctangent table of the heading smoother
`timescale 1ns / 1ps
`default_nettype none

package chs_pkg;

	// sequencer states of the top level
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_SUM,
		ST_REDUCE,
		ST_MUL1,
		ST_MUL2,
		ST_DONE
	} chs_state_t;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd2;

	localparam logic [15:0] ALPHA_RESET = 16'd52429;

	// q1.16 constants for the blend
	localparam logic [16:0] Q16_ONE  = 17'h10000;
	localparam int          Q16_HALF = 32768;

	// angle accumulator units are 1/65536 degree
	localparam int ATAN_W      = 22;
	localparam int TABLE_LEN   = 24;
	localparam int HALF_TURN_Z = 180 * 65536;

	// atan(2^-i) in degrees, scaled by 65536 and rounded
	function automatic logic [ATAN_W-1:0] atan_entry(input logic [4:0] idx);
		unique case (idx)
			5'd0:    atan_entry = 22'd2949120;
			5'd1:    atan_entry = 22'd1740967;
			5'd2:    atan_entry = 22'd919879;
			5'd3:    atan_entry = 22'd466945;
			5'd4:    atan_entry = 22'd234379;
			5'd5:    atan_entry = 22'd117304;
			5'd6:    atan_entry = 22'd58666;
			5'd7:    atan_entry = 22'd29335;
			5'd8:    atan_entry = 22'd14668;
			5'd9:    atan_entry = 22'd7334;
			5'd10:   atan_entry = 22'd3667;
			5'd11:   atan_entry = 22'd1833;
			5'd12:   atan_entry = 22'd917;
			5'd13:   atan_entry = 22'd458;
			5'd14:   atan_entry = 22'd229;
			5'd15:   atan_entry = 22'd115;
			5'd16:   atan_entry = 22'd57;
			5'd17:   atan_entry = 22'd29;
			5'd18:   atan_entry = 22'd14;
			5'd19:   atan_entry = 22'd7;
			5'd20:   atan_entry = 22'd4;
			5'd21:   atan_entry = 22'd2;
			5'd22:   atan_entry = 22'd1;
			default: atan_entry = 22'd0;
		endcase
	endfunction

endpackage

`default_nettype wire

// ===== design/chs_cordic.sv =====
// iterative vectoring cordic: atan2 of one sample, one micro-rotation per cycle
`timescale 1ns / 1ps
`default_nettype none

module chs_cordic #(
	parameter int ITERATIONS = 16,
	parameter int FRAC_BITS  = 6,
	localparam int RAW_W     = 10 + FRAC_BITS
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [15:0]      x,
	input  wire logic signed [15:0]      y,
	output logic                         done,
	output logic signed [RAW_W-1:0]      angle
);

	localparam int XY_W = 27;
	localparam int Z_W  = 26;
	localparam int IW   = $clog2(ITERATIONS);
	localparam int ZSH  = 16 - FRAC_BITS;

	localparam logic signed [Z_W-1:0] Z_ROUND = Z_W'(1 << (15 - FRAC_BITS));
	localparam logic signed [Z_W-1:0] Z_HALF  = Z_W'(chs_pkg::HALF_TURN_Z);
	localparam logic [IW-1:0]         I_LAST  = IW'(ITERATIONS - 1);

	logic                    busy_q;
	logic                    fin_q;
	logic                    done_q;
	logic [IW-1:0]           i_q;
	logic                    zero_q;
	logic signed [XY_W-1:0]  x_q;
	logic signed [XY_W-1:0]  y_q;
	logic signed [Z_W-1:0]   z_q;
	logic signed [RAW_W-1:0] angle_q;

	logic signed [16:0]      x_ext;
	logic signed [16:0]      y_ext;
	logic signed [16:0]      x_pre;
	logic signed [16:0]      y_pre;
	logic signed [24:0]      x_scl;
	logic signed [24:0]      y_scl;
	logic signed [XY_W-1:0]  dx;
	logic signed [XY_W-1:0]  dy;
	logic signed [Z_W-1:0]   step_z;
	logic signed [Z_W-1:0]   z_rnd;
	logic signed [Z_W-1:0]   z_shr;

	// left half plane is turned by 180 degrees first
	always_comb begin
		x_ext = 17'(x);
		y_ext = 17'(y);
		x_pre = x[15] ? -x_ext : x_ext;
		y_pre = x[15] ? -y_ext : y_ext;
		x_scl = $signed({x_pre, 8'h00});
		y_scl = $signed({y_pre, 8'h00});
	end

	// shared shifter and table lookup for the current micro-rotation
	always_comb begin
		dx     = y_q >>> i_q;
		dy     = x_q >>> i_q;
		step_z = $signed(Z_W'(chs_pkg::atan_entry(5'(i_q))));
		z_rnd  = z_q + Z_ROUND;
		z_shr  = z_rnd >>> ZSH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == I_LAST) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= XY_W'(x_scl);
			y_q    <= XY_W'(y_scl);
			z_q    <= x[15] ? Z_HALF : '0;
			zero_q <= (x == 16'sd0) && (y == 16'sd0);
		end else if (busy_q) begin
			if (!y_q[XY_W-1]) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + step_z;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - step_z;
			end
		end
		// zero vector has no direction, report zero
		if (fin_q) begin
			angle_q <= zero_q ? '0 : RAW_W'(z_shr);
		end
	end

	assign done  = done_q;
	assign angle = angle_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (!busy_q && !fin_q))
		else $error("cordic started while busy");

	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(fin_q))
		else $error("cordic done without final rounding step");

	a_fin_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |=> !fin_q && !busy_q)
		else $error("cordic rounding step not a single cycle");
`endif

endmodule

`default_nettype wire

// ===== design/compass_heading_smoother.sv =====
// top level of the compass heading smoother: sequencer, range reduction and blend
//
// usage:
//   input channel: one beat carries a magnetometer sample (mag_x, mag_y); it is taken
//   at a clock edge with in_valid high and in_stall low. in_stall is high while an
//   item is in progress, so one sample is worked on at a time.
//   output channel: one beat per sample, heading (1/2^ANGLE_FRACTION_BITS degree)
//   and heading_valid; it is taken with out_valid high and out_stall low.
//   config port: cfg_we writes cfg_data into register cfg_index (0 enable,
//   1 calibration offset, 2 smoothing alpha); write only while the block is idle.
// sequence:
//   an enabled sample runs the cordic micro-rotations (one per cycle), a sum step,
//   NRED compare-subtract steps that fold the angle into one turn (4 at 1/64
//   degree) and the blend multiply steps MUL1 and MUL2 before the result is
//   registered; the first sample skips the blend. a disabled sample returns the
//   held heading. the next sample can be taken in the cycle after a result is registered.
// reset clears the filtered heading, the first-sample flag, enable and offset, and sets alpha to ALPHA_RESET.
// a stalled receiver holds the result register; a finished item then waits
// until the register is free, and input stays stalled meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module compass_heading_smoother #(
	parameter int CORDIC_ITERATIONS   = 16,
	parameter int ANGLE_FRACTION_BITS = 6
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [chs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [chs_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic signed [15:0]              mag_x,
	input  wire logic signed [15:0]              mag_y,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [14:0]                          heading,
	output logic                                 heading_valid
);

	localparam int RAW_W     = 10 + ANGLE_FRACTION_BITS;
	localparam int FULL_TURN = 360 * (2 ** ANGLE_FRACTION_BITS);
	localparam int FH_W      = $clog2(FULL_TURN);
	localparam int SUM_W     = ((RAW_W > 16) ? RAW_W : 16) + 1;
	localparam int RED_W     = SUM_W + 2;
	localparam int NRED      = SUM_W + 2 - $clog2(FULL_TURN);
	localparam int CNT_W     = $clog2(NRED);
	localparam int BIAS      = ((2 ** (SUM_W - 1)) / FULL_TURN + 1) * FULL_TURN;
	localparam int ACC_W     = FH_W + 17;

	localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(NRED - 1);

	chs_pkg::chs_state_t state_q;
	chs_pkg::chs_state_t state_d;

	// config registers
	logic               en_q;
	logic signed [15:0] offset_q;
	logic [15:0]        alpha_q;

	// filter state
	logic [FH_W-1:0]    fh_q;
	logic               seen_q;

	// per-item working registers
	logic               item_en_q;
	logic [RED_W-1:0]   v_q;
	logic [CNT_W-1:0]   red_cnt_q;
	logic [ACC_W-1:0]   acc_q;

	// result register
	logic               out_valid_q;
	logic [14:0]        heading_q;
	logic               heading_valid_q;

	logic               in_accept;
	logic               out_free;
	logic               out_load;
	logic               cordic_start;
	logic               cordic_done;
	logic signed [RAW_W-1:0] raw_angle;

	logic signed [RED_W-1:0] raw_ext;
	logic signed [RED_W-1:0] off_ext;
	logic signed [RED_W-1:0] sum_v;
	logic [RED_W-1:0]   red_step;
	logic [FH_W-1:0]    corr;
	logic [16:0]        w_new;
	logic [FH_W-1:0]    mul_a;
	logic [16:0]        mul_b;
	logic [ACC_W-1:0]   prod;
	logic [ACC_W-1:0]   acc_base;
	logic [FH_W-1:0]    fh_new;

	chs_cordic #(
		.ITERATIONS (CORDIC_ITERATIONS),
		.FRAC_BITS  (ANGLE_FRACTION_BITS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.x      (mag_x),
		.y      (mag_y),
		.done   (cordic_done),
		.angle  (raw_angle)
	);

	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			chs_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = en_q ? chs_pkg::ST_CORDIC : chs_pkg::ST_DONE;
				end
			end
			chs_pkg::ST_CORDIC: begin
				if (cordic_done) begin
					state_d = chs_pkg::ST_SUM;
				end
			end
			chs_pkg::ST_SUM: begin
				state_d = chs_pkg::ST_REDUCE;
			end
			chs_pkg::ST_REDUCE: begin
				if (red_cnt_q == '0) begin
					state_d = seen_q ? chs_pkg::ST_MUL1 : chs_pkg::ST_DONE;
				end
			end
			chs_pkg::ST_MUL1: begin
				state_d = chs_pkg::ST_MUL2;
			end
			chs_pkg::ST_MUL2: begin
				state_d = chs_pkg::ST_DONE;
			end
			chs_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = chs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = chs_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall     = (state_q != chs_pkg::ST_IDLE);
		cordic_start = (state_q == chs_pkg::ST_IDLE) && in_valid && en_q;
		out_load     = (state_q == chs_pkg::ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q     <= 1'b0;
			offset_q <= '0;
			alpha_q  <= chs_pkg::ALPHA_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				chs_pkg::REG_ENABLE: en_q     <= cfg_data[0];
				chs_pkg::REG_OFFSET: offset_q <= $signed(cfg_data);
				chs_pkg::REG_ALPHA:  alpha_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// offset plus a whole number of turns keeps the sum non-negative
	always_comb begin
		raw_ext  = RED_W'(raw_angle);
		off_ext  = RED_W'(offset_q);
		sum_v    = raw_ext + off_ext + RED_W'(BIAS);
		red_step = RED_W'(FULL_TURN) << red_cnt_q;
		corr     = FH_W'(v_q);
	end

	// one multiplier: old * alpha, then new * (1 - alpha)
	always_comb begin
		w_new = chs_pkg::Q16_ONE - {1'b0, alpha_q};
		if (state_q == chs_pkg::ST_MUL1) begin
			mul_a    = fh_q;
			mul_b    = {1'b0, alpha_q};
			acc_base = ACC_W'(chs_pkg::Q16_HALF);
		end else begin
			mul_a    = corr;
			mul_b    = w_new;
			acc_base = acc_q;
		end
		prod = ACC_W'(mul_a) * ACC_W'(mul_b);
	end

	always_comb begin
		if (!item_en_q) begin
			fh_new = fh_q;
		end else if (!seen_q) begin
			fh_new = corr;
		end else begin
			fh_new = acc_q[16 +: FH_W];
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_en_q <= en_q;
		end
		if (state_q == chs_pkg::ST_SUM) begin
			v_q       <= sum_v;
			red_cnt_q <= CNT_TOP;
		end else if (state_q == chs_pkg::ST_REDUCE) begin
			if (v_q >= red_step) begin
				v_q <= v_q - red_step;
			end
			red_cnt_q <= red_cnt_q - 1'b1;
		end
		if (state_q == chs_pkg::ST_MUL1 || state_q == chs_pkg::ST_MUL2) begin
			acc_q <= acc_base + prod;
		end
		if (out_load) begin
			heading_q       <= 15'(fh_new);
			heading_valid_q <= item_en_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fh_q        <= '0;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				fh_q        <= fh_new;
				seen_q      <= seen_q || item_en_q;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign heading       = heading_q;
	assign heading_valid = heading_valid_q;

`ifndef SYNTHESIS
	a_fh_in_turn: assert property (@(posedge clk) disable iff (!arst_n)
		fh_q < FH_W'(FULL_TURN))
		else $error("filtered heading outside one turn");

	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == chs_pkg::ST_REDUCE && red_cnt_q == '0) |=> v_q < RED_W'(FULL_TURN))
		else $error("range reduction left more than one turn");

	a_cordic_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		cordic_done |-> state_q == chs_pkg::ST_CORDIC)
		else $error("cordic result outside the wait state");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == chs_pkg::ST_DONE))
		else $error("result beat not from the done state");

	a_disabled_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && !item_en_q) |=> $stable(fh_q) && $stable(seen_q))
		else $error("disabled sample changed the filter state");
`endif

endmodule

`default_nettype wire
